@@ hdl/hsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types, constants and the CRC-8 byte update for the sensor frame
// checker and converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

	localparam logic [7:0]  CRC_POLY  = 8'h31;
	localparam logic [7:0]  CRC_INIT  = 8'hFF;
	localparam logic [17:0] DEN2      = 18'd131070;
	localparam int unsigned T_OFFSET  = 89 * 65535;
	localparam int unsigned H_OFFSET  = 65535;
	localparam int unsigned T_SCALE   = 350;
	localparam int unsigned H_SCALE   = 200;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TEMP_BAD = 2'd1;
	localparam logic [1:0] ST_HUM_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] raw_temperature;
		logic [15:0] raw_humidity;
	} job_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/hsfc_byte_if.sv @@
// ----------------------------------------------------------------------------
// hsfc_byte_if
// Byte channel into the frame checker: one frame byte per beat.
// ----------------------------------------------------------------------------
interface hsfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       first_byte;

	modport source (output valid, output rx_byte, output first_byte, input ready);
	modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

@@ hdl/hsfc_result_if.sv @@
// ----------------------------------------------------------------------------
// hsfc_result_if
// Result channel: one checked and converted measurement per beat.
// ----------------------------------------------------------------------------
interface hsfc_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [15:0]       raw_temperature;
	logic [15:0]       raw_humidity;
	logic signed [8:0] temperature_celsius;
	logic [6:0]        humidity_percent;

	modport source (output valid, output status, output raw_temperature,
		output raw_humidity, output temperature_celsius, output humidity_percent,
		input ready);
	modport sink   (input valid, input status, input raw_temperature,
		input raw_humidity, input temperature_celsius, input humidity_percent,
		output ready);
endinterface

@@ hdl/humidity_sensor_frame_check_convert.sv @@
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert
// Checks the two CRC-8 bytes of a six-byte sensor frame and converts both
// raw words to whole degrees Celsius and percent relative humidity.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle; the front stalls only when the queue
// of finished frames is full.
// Path: a frame is pushed into the queue when its sixth byte is taken, then
// passes the three converter stages ahead of the output register; the queue
// and each stage hold their frame while the result channel stalls.
// Reset clears the frame position, CRC, error flag, queue and all valid bits.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_check_convert
	import hsfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	hsfc_byte_if.sink     rx,
	hsfc_result_if.source meas
);

	logic push_valid;
	job_t push_job;
	logic full;
	logic pop_valid;
	job_t pop_job;
	logic pop_ready;

	hsfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (full)
	);

	hsfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (full),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	hsfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.meas      (meas)
	);

endmodule

@@ hdl/hsfc_front.sv @@
// ----------------------------------------------------------------------------
// hsfc_front
// Tracks the frame position, runs the CRC-8 checks, assembles both words and
// hands a finished frame to the queue.
// ----------------------------------------------------------------------------
module hsfc_front
	import hsfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hsfc_byte_if.sink   rx,
	output logic        push_valid,
	output job_t        push_job,
	input  logic        full
);

	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [1:0]  err_q;
	logic [15:0] traw_q;
	logic [15:0] hraw_q;

	logic        accept;
	logic        restart;
	logic [2:0]  pos;
	logic [7:0]  crc_base;
	logic [1:0]  err_base;
	logic [7:0]  crc_next;
	logic [1:0]  err_final;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;
	assign restart  = rx.first_byte || (pos_q > POS_H_CRC);
	assign pos      = restart ? POS_T_MSB : pos_q;
	assign crc_base = restart ? CRC_INIT : crc_q;
	assign err_base = restart ? ST_OK : err_q;
	assign crc_next = crc_byte(crc_base, rx.rx_byte);

	assign err_final = (err_base == ST_OK && crc_base != rx.rx_byte) ? ST_HUM_BAD : err_base;

	assign push_valid               = accept && (pos == POS_H_CRC);
	assign push_job.status          = err_final;
	assign push_job.raw_temperature = traw_q;
	assign push_job.raw_humidity    = hraw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_T_MSB;
			crc_q <= CRC_INIT;
			err_q <= ST_OK;
		end else if (accept) begin
			pos_q <= (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
			unique case (pos)
				POS_T_MSB, POS_T_LSB, POS_H_MSB, POS_H_LSB: begin
					crc_q <= crc_next;
					err_q <= err_base;
				end
				POS_T_CRC: begin
					crc_q <= CRC_INIT;
					err_q <= (crc_base != rx.rx_byte) ? ST_TEMP_BAD : ST_OK;
				end
				default: begin
					crc_q <= CRC_INIT;
					err_q <= err_final;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (pos)
				POS_T_MSB: traw_q[15:8] <= rx.rx_byte;
				POS_T_LSB: traw_q[7:0]  <= rx.rx_byte;
				POS_H_MSB: hraw_q[15:8] <= rx.rx_byte;
				POS_H_LSB: hraw_q[7:0]  <= rx.rx_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hdl/hsfc_queue.sv @@
// ----------------------------------------------------------------------------
// hsfc_queue
// Two-entry queue of finished frames between the checker and the converter.
// ----------------------------------------------------------------------------
module hsfc_queue
	import hsfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  job_t push_job,
	output logic full,
	output logic pop_valid,
	output job_t pop_job,
	input  logic pop_ready
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_job   = entry_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ hdl/hsfc_back.sv @@
// ----------------------------------------------------------------------------
// hsfc_back
// Converter pipeline: scales both raw words and divides by 131070 through a
// shift estimate with one correction step, then holds the result for output.
// ----------------------------------------------------------------------------
module hsfc_back
	import hsfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  job_t          pop_job,
	output logic          pop_ready,
	hsfc_result_if.source meas
);

	logic               v_s1, v_s2, v_s3, v_out_q;
	logic               en_s1, en_s2, en_s3, en_out;

	job_t               job_s1, job_s2, job_s3, job_out_q;
	logic signed [25:0] tn_s1;
	logic [23:0]        hn_s1;
	logic [24:0]        tmag_s2;
	logic               tneg_s2, tneg_s3;
	logic [23:0]        hmag_s2;
	logic [7:0]         tq0_s3;
	logic [17:0]        tr_s3;
	logic [6:0]         hq0_s3;
	logic [17:0]        hr_s3;
	logic signed [8:0]  temp_out_q;
	logic [6:0]         hum_out_q;

	logic [24:0]        tprod;
	logic [7:0]         tq0;
	logic [6:0]         hq0;
	logic [24:0]        trem;
	logic [23:0]        hrem;
	logic [8:0]         tq;
	logic [6:0]         hq;

	assign en_out    = !v_out_q || meas.ready;
	assign en_s3     = !v_s3 || en_out;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pop_ready = en_s1;

	assign tprod = 25'(pop_job.raw_temperature) * 25'(T_SCALE);
	assign tq0   = tmag_s2[24:17];
	assign hq0   = hmag_s2[23:17];
	assign trem  = tmag_s2 - ((25'(tq0) << 17) - (25'(tq0) << 1));
	assign hrem  = hmag_s2 - ((24'(hq0) << 17) - (24'(hq0) << 1));
	assign tq    = 9'(tq0_s3) + 9'(tr_s3 >= DEN2);
	assign hq    = hq0_s3 + 7'(hr_s3 >= DEN2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= pop_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				v_out_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			job_s1 <= pop_job;
			tn_s1  <= $signed({1'b0, tprod}) - $signed(26'(T_OFFSET));
			hn_s1  <= 24'(pop_job.raw_humidity) * 24'(H_SCALE) + 24'(H_OFFSET);
		end
		if (en_s2) begin
			job_s2  <= job_s1;
			tneg_s2 <= tn_s1[25];
			tmag_s2 <= tn_s1[25] ? 25'(-tn_s1) : tn_s1[24:0];
			hmag_s2 <= hn_s1;
		end
		if (en_s3) begin
			job_s3  <= job_s2;
			tneg_s3 <= tneg_s2;
			tq0_s3  <= tq0;
			tr_s3   <= trem[17:0];
			hq0_s3  <= hq0;
			hr_s3   <= hrem[17:0];
		end
		if (en_out) begin
			job_out_q  <= job_s3;
			temp_out_q <= tneg_s3 ? $signed(-tq) : $signed(tq);
			hum_out_q  <= hq;
		end
	end

	assign meas.valid               = v_out_q;
	assign meas.status              = job_out_q.status;
	assign meas.raw_temperature     = job_out_q.raw_temperature;
	assign meas.raw_humidity        = job_out_q.raw_humidity;
	assign meas.temperature_celsius = temp_out_q;
	assign meas.humidity_percent    = hum_out_q;

endmodule

@@ hdl/hsfc_checker.sv @@
// ----------------------------------------------------------------------------
// hsfc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hsfc_checker
	import hsfc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              valid,
	input logic              ready,
	input logic [1:0]        status,
	input logic [15:0]       raw_temperature,
	input logic [15:0]       raw_humidity,
	input logic signed [8:0] temperature_celsius,
	input logic [6:0]        humidity_percent
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (status == ST_OK || status == ST_TEMP_BAD || status == ST_HUM_BAD))
		else $error("Result status code out of range.");

	a_humidity_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (humidity_percent <= 7'd100))
		else $error("Humidity percent above full scale.");

	a_temperature_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (temperature_celsius >= -9'sd45 && temperature_celsius <= 9'sd130))
		else $error("Temperature outside the sensor range.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(status) && $stable(raw_temperature)
			&& $stable(raw_humidity) && $stable(temperature_celsius)
			&& $stable(humidity_percent))
		else $error("Stalled result beat changed.");

endmodule

bind humidity_sensor_frame_check_convert hsfc_checker u_hsfc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.valid               (meas.valid),
	.ready               (meas.ready),
	.status              (meas.status),
	.raw_temperature     (meas.raw_temperature),
	.raw_humidity        (meas.raw_humidity),
	.temperature_celsius (meas.temperature_celsius),
	.humidity_percent    (meas.humidity_percent)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives six-byte sensor frames into the frame checker one byte per beat and
// checks every measurement beat against the table's values or an in-bench model
// of the CRC checks and the conversion. A short table of extreme frames comes
// first, then mostly well-formed random frames mixed with cut-short ones and noise.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsfc_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] raw_t;
		logic [15:0] raw_h;
		logic [8:0]  celsius;
		logic [6:0]  percent;
	} reading_t;

	typedef enum logic [1:0] {BYTE_LIT, BYTE_CRC_OK, BYTE_CRC_BAD} byte_kind_e;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		byte_kind_e kind;
		logic       typed;
		reading_t   want;
	} frame_row_t;

	localparam int N_ROWS = 26;
	localparam int N_RANDOM_BEATS = 750;

	logic clk = 1'b0;
	logic arst_n;
	logic calm;
	int   mismatches;

	logic [2:0]  frame_pos;
	logic [7:0]  crc_run;
	logic [15:0] words [2];
	logic [1:0]  frame_err;

	reading_t pending_meas [$];

	hsfc_byte_if   rx_bus();
	hsfc_result_if meas_bus();

	humidity_sensor_frame_check_convert u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_bus),
		.meas   (meas_bus)
	);

	// Frames at the extremes of both words, a frame without the start mark, a
	// restart in the middle of a frame, both CRCs bad and only the humidity CRC bad.
	frame_row_t frame_rows [N_ROWS] = '{
		'{8'h00, 1'b1, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, '0},
		'{8'h00, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_OK,  1'b1, '{ST_OK, 16'h0000, 16'h0000, -9'sd44, 7'd0}},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, '0},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_OK,  1'b1, '{ST_OK, 16'hFFFF, 16'hFFFF, 9'sd130, 7'd100}},
		'{8'hBE, 1'b1, BYTE_LIT,     1'b0, '0},
		'{8'hEF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b1, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_BAD, 1'b0, '0},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_BAD, 1'b1, '{ST_TEMP_BAD, 16'h0000, 16'hFFFF, -9'sd44, 7'd100}},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'hFF, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_OK,  1'b0, '0},
		'{8'h00, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_LIT,     1'b0, '0},
		'{8'h00, 1'b0, BYTE_CRC_BAD, 1'b1, '{ST_HUM_BAD, 16'hFFFF, 16'h0000, 9'sd130, 7'd0}}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
		return r;
	endfunction

	function automatic logic [7:0] word_crc(input logic [15:0] w);
		return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			default: begin
				return 16'($urandom_range(16'hFFFF));
			end
		endcase
	endfunction

	task automatic frame_track(input logic [7:0] b, input logic f, output logic done,
		output reading_t got);
		int unsigned p;
		longint tn;
		longint hn;
		p = frame_pos;
		got = '0;
		if (f || p > 5) begin
			p = 0;
			crc_run = CRC_INIT;
			frame_err = ST_OK;
		end
		case (p)
			0, 3: begin
				words[p / 3] = {b, 8'h00};
				crc_run = crc8_step(crc_run, b);
			end
			1, 4: begin
				words[p / 3][7:0] = b;
				crc_run = crc8_step(crc_run, b);
			end
			2: begin
				frame_err = (crc_run != b) ? ST_TEMP_BAD : ST_OK;
				crc_run = CRC_INIT;
			end
			default: begin
				if (frame_err == ST_OK && crc_run != b) begin
					frame_err = ST_HUM_BAD;
				end
				crc_run = CRC_INIT;
			end
		endcase
		frame_pos = 3'((p + 1) % 6);
		done = (p == 5);
		if (done) begin
			tn = longint'(T_SCALE) * longint'(words[0]) - longint'(T_OFFSET);
			hn = longint'(H_SCALE) * longint'(words[1]) + longint'(H_OFFSET);
			got.status = frame_err;
			got.raw_t = words[0];
			got.raw_h = words[1];
			got.celsius = 9'(tn / longint'(DEN2));
			got.percent = 7'(hn / longint'(DEN2));
		end
	endtask

	task automatic send_byte(input logic [7:0] d, input logic f, input logic typed,
		input reading_t want);
		logic done;
		reading_t got;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 27) begin
			rx_bus.valid <= 1'b0;
			@(negedge clk);
		end
		rx_bus.valid <= 1'b1;
		rx_bus.rx_byte <= d;
		rx_bus.first_byte <= f;
		@(posedge clk);
		while (!rx_bus.ready) begin
			@(posedge clk);
		end
		frame_track(d, f, done, got);
		if (done) begin
			pending_meas.push_back(typed ? want : got);
		end
	endtask

	always @(negedge clk) begin
		meas_bus.ready <= calm || ($urandom_range(99) >= 27);
	end

	always @(posedge clk) begin : watch_meas
		reading_t want;
		if (arst_n && meas_bus.valid && meas_bus.ready) begin
			if (pending_meas.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Measurement beat with none expected: status %0d raw %h %h",
						meas_bus.status, meas_bus.raw_temperature, meas_bus.raw_humidity);
				end
			end else begin
				want = pending_meas.pop_front();
				if (want.status !== meas_bus.status || want.raw_t !== meas_bus.raw_temperature
					|| want.raw_h !== meas_bus.raw_humidity
					|| want.celsius !== meas_bus.temperature_celsius
					|| want.percent !== meas_bus.humidity_percent) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch: expected status %0d raw %h %h degC %0d rh %0d",
							want.status, want.raw_t, want.raw_h, $signed(want.celsius),
							want.percent);
						$display("          got      status %0d raw %h %h degC %0d rh %0d",
							meas_bus.status, meas_bus.raw_temperature, meas_bus.raw_humidity,
							$signed(meas_bus.temperature_celsius), meas_bus.humidity_percent);
					end
				end
			end
		end
	end

	initial begin : stimulus
		reading_t nil;
		logic [7:0] recent [2];
		logic [7:0] frame [6];
		logic [7:0] d;
		logic [15:0] t_word;
		logic [15:0] h_word;
		logic lead;
		int n_bytes;
		int mode;
		int rand_beats;
		nil = '0;
		mismatches = 0;
		calm = 1'b0;
		rand_beats = 0;
		recent[0] = 8'h00;
		recent[1] = 8'h00;
		frame_pos = 3'd0;
		crc_run = CRC_INIT;
		words[0] = 16'h0000;
		words[1] = 16'h0000;
		frame_err = ST_OK;
		rx_bus.valid = 1'b0;
		rx_bus.rx_byte = 8'h00;
		rx_bus.first_byte = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_ROWS; i++) begin
			case (frame_rows[i].kind)
				BYTE_CRC_OK: begin
					d = word_crc({recent[0], recent[1]});
				end
				BYTE_CRC_BAD: begin
					d = word_crc({recent[0], recent[1]}) ^ 8'hFF;
				end
				default: begin
					d = frame_rows[i].data;
				end
			endcase
			send_byte(d, frame_rows[i].first, frame_rows[i].typed, frame_rows[i].want);
			recent[0] = recent[1];
			recent[1] = d;
		end

		while (rand_beats < N_RANDOM_BEATS) begin
			calm = (rand_beats >= 300 && rand_beats < 420);
			mode = $urandom_range(99);
			if (mode < 85) begin
				t_word = pick_word();
				h_word = pick_word();
				frame[0] = t_word[15:8];
				frame[1] = t_word[7:0];
				frame[2] = word_crc(t_word)
					^ (($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00);
				frame[3] = h_word[15:8];
				frame[4] = h_word[7:0];
				frame[5] = word_crc(h_word)
					^ (($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00);
				if (mode < 70) begin
					n_bytes = 6;
					lead = ($urandom_range(9) != 0);
				end else begin
					n_bytes = $urandom_range(1, 5);
					lead = 1'b1;
				end
				for (int i = 0; i < n_bytes; i++) begin
					send_byte(frame[i], (i == 0) ? lead : 1'b0, 1'b0, nil);
				end
				rand_beats += n_bytes;
			end else begin
				n_bytes = $urandom_range(1, 4);
				repeat (n_bytes) begin
					send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, nil);
				end
				rand_beats += n_bytes;
			end
		end
		calm = 1'b0;

		@(negedge clk);
		rx_bus.valid <= 1'b0;
		while (pending_meas.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/hsfc_pkg.sv
hdl/hsfc_byte_if.sv
hdl/hsfc_result_if.sv
hdl/hsfc_front.sv
hdl/hsfc_queue.sv
hdl/hsfc_back.sv
hdl/humidity_sensor_frame_check_convert.sv
hdl/hsfc_checker.sv
bench/tb.sv
